// ----- hdl/stt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared constants, token kinds, the token and bundle types, and the
// character classification functions used by the front end.
// ----------------------------------------------------------------------------
package stt_pkg;

   // Default saturation limits, handed down from the top level.
   localparam longint unsigned MaxLineDefault       = 64'd65535;
   localparam longint unsigned MaxColumnDefault     = 64'd65535;
   localparam longint unsigned MaxWordLengthDefault = 64'd255;

   // Field widths of the request and response channels.
   localparam int ByteW   = 8;
   localparam int KindW   = 5;
   localparam int LineW   = 16;
   localparam int ColumnW = 16;
   localparam int LengthW = 8;

   // Token kinds.
   localparam logic [KindW-1:0] KindNumber    = 5'd0;
   localparam logic [KindW-1:0] KindIdent     = 5'd1;
   localparam logic [KindW-1:0] KindIf        = 5'd2;
   localparam logic [KindW-1:0] KindElse      = 5'd3;
   localparam logic [KindW-1:0] KindPrint     = 5'd4;
   localparam logic [KindW-1:0] KindPlus      = 5'd5;
   localparam logic [KindW-1:0] KindMinus     = 5'd6;
   localparam logic [KindW-1:0] KindMultiply  = 5'd7;
   localparam logic [KindW-1:0] KindDivide    = 5'd8;
   localparam logic [KindW-1:0] KindAssign    = 5'd9;
   localparam logic [KindW-1:0] KindLParen    = 5'd10;
   localparam logic [KindW-1:0] KindRParen    = 5'd11;
   localparam logic [KindW-1:0] KindLBrace    = 5'd12;
   localparam logic [KindW-1:0] KindRBrace    = 5'd13;
   localparam logic [KindW-1:0] KindSemicolon = 5'd14;
   localparam logic [KindW-1:0] KindGt        = 5'd15;
   localparam logic [KindW-1:0] KindLt        = 5'd16;
   localparam logic [KindW-1:0] KindEq        = 5'd17;
   localparam logic [KindW-1:0] KindLe        = 5'd18;
   localparam logic [KindW-1:0] KindGe        = 5'd19;
   localparam logic [KindW-1:0] KindNe        = 5'd20;
   localparam logic [KindW-1:0] KindEnd       = 5'd21;

   // Keyword matcher codes.
   localparam logic [3:0] KwStart = 4'd0;
   localparam logic [3:0] KwI     = 4'd1;
   localparam logic [3:0] KwIf    = 4'd2;
   localparam logic [3:0] KwE     = 4'd3;
   localparam logic [3:0] KwEl    = 4'd4;
   localparam logic [3:0] KwEls   = 4'd5;
   localparam logic [3:0] KwElse  = 4'd6;
   localparam logic [3:0] KwP     = 4'd7;
   localparam logic [3:0] KwPr    = 4'd8;
   localparam logic [3:0] KwPri   = 4'd9;
   localparam logic [3:0] KwPrin  = 4'd10;
   localparam logic [3:0] KwPrint = 4'd11;
   localparam logic [3:0] KwNone  = 4'd15;

   // One request byte gives at most three tokens.
   localparam int BundleSlots = 3;
   localparam int SlotW       = 2;

   // Depth of the queue between front and back end.
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [KindW-1:0]   kind;
      logic [LineW-1:0]   line;
      logic [ColumnW-1:0] column;
      logic [LengthW-1:0] length;
   } tok_type;

   typedef struct packed {
      logic [SlotW-1:0]                 cnt;
      tok_type [BundleSlots-1:0]        tok;
   } bundle_type;

   // Whitespace: space, tab, LF, VT, FF, CR.
   function automatic logic is_space(input logic [ByteW-1:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_symbol(input logic [ByteW-1:0] c);
      return c == "(" || c == ")" || c == "{" || c == "}" || c == "+" ||
             c == "-" || c == "*" || c == "/" || c == "=" || c == ";" ||
             c == "<" || c == ">" || c == "!" || c == "," || c == ".";
   endfunction

   function automatic logic is_digit(input logic [ByteW-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Kind of a one-byte symbol; bang, comma and dot fall back to identifier.
   function automatic logic [KindW-1:0] single_kind(input logic [ByteW-1:0] c);
      logic [KindW-1:0] k;
      case (c)
         "+": k = KindPlus;
         "-": k = KindMinus;
         "*": k = KindMultiply;
         "/": k = KindDivide;
         "=": k = KindAssign;
         "(": k = KindLParen;
         ")": k = KindRParen;
         "{": k = KindLBrace;
         "}": k = KindRBrace;
         ";": k = KindSemicolon;
         ">": k = KindGt;
         "<": k = KindLt;
         default: k = KindIdent;
      endcase
      return k;
   endfunction

   // Kind of a two-byte operator, keyed on its first byte.
   function automatic logic [KindW-1:0] pair_kind(input logic [ByteW-1:0] c);
      logic [KindW-1:0] k;
      case (c)
         "=": k = KindEq;
         "<": k = KindLe;
         ">": k = KindGe;
         default: k = KindNe;
      endcase
      return k;
   endfunction

   // Keyword matcher: advances over if, else and print.
   function automatic logic [3:0] kw_next(input logic [3:0] s, input logic [ByteW-1:0] c);
      logic [3:0] n;
      n = KwNone;
      case (s)
         KwStart: begin
            if (c == "i") n = KwI;
            else if (c == "e") n = KwE;
            else if (c == "p") n = KwP;
         end
         KwI:    if (c == "f") n = KwIf;
         KwE:    if (c == "l") n = KwEl;
         KwEl:   if (c == "s") n = KwEls;
         KwEls:  if (c == "e") n = KwElse;
         KwP:    if (c == "r") n = KwPr;
         KwPr:   if (c == "i") n = KwPri;
         KwPri:  if (c == "n") n = KwPrin;
         KwPrin: if (c == "t") n = KwPrint;
         default: n = KwNone;
      endcase
      return n;
   endfunction

   function automatic logic [KindW-1:0] word_kind(input logic digits, input logic [3:0] kw);
      logic [KindW-1:0] k;
      if (digits) k = KindNumber;
      else if (kw == KwIf) k = KindIf;
      else if (kw == KwElse) k = KindElse;
      else if (kw == KwPrint) k = KindPrint;
      else k = KindIdent;
      return k;
   endfunction

   // Builds a token, clamping each count to the width of its field.
   function automatic tok_type tok_make(input logic [KindW-1:0] kind,
                                        input logic [63:0] line,
                                        input logic [63:0] column,
                                        input logic [63:0] length);
      tok_type t;
      t.kind   = kind;
      t.line   = (line   > 64'hFFFF) ? '1 : line[LineW-1:0];
      t.column = (column > 64'hFFFF) ? '1 : column[ColumnW-1:0];
      t.length = (length > 64'hFF)   ? '1 : length[LengthW-1:0];
      return t;
   endfunction

endpackage

// ----- hdl/stt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer channels
// Valid/ready channels for the text bytes in and the tokens out.
// ----------------------------------------------------------------------------

// Request channel: one source text byte per request.
interface stt_req_if;
   logic                      valid;
   logic                      ready;
   logic [stt_pkg::ByteW-1:0] text_byte;
   logic                      end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// Response channel: one token per transfer.
interface stt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [stt_pkg::KindW-1:0]   token_kind;
   logic [stt_pkg::LineW-1:0]   start_line;
   logic [stt_pkg::ColumnW-1:0] start_column;
   logic [stt_pkg::LengthW-1:0] token_length;
   logic                        run_last;

   modport source (output valid, output token_kind, output start_line, output start_column,
                   output token_length, output run_last, input ready);
   modport sink   (input valid, input token_kind, input start_line, input start_column,
                   input token_length, input run_last, output ready);
endinterface

// ----- hdl/source_text_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexical analyser: text bytes in, typed tokens with position out.
// ----------------------------------------------------------------------------
// The block takes one source text byte per cycle whenever its four-entry
// bundle queue has room, and hands out one token per cycle while the receiver
// is ready. A byte that completes several tokens (at most three, at end of
// text) takes one response transfer per token; the queue between the scanning
// front end and the output register absorbs such bursts, so the request side
// stalls only when four bundles are waiting. Line, column and word length
// counters saturate at MAX_LINE, MAX_COLUMN and MAX_WORD_LENGTH, and the
// reported values are further clamped to the field widths. After the byte
// marked end of text the scanner returns to its reset state for a new text.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
   parameter longint unsigned MAX_LINE        = stt_pkg::MaxLineDefault,
   parameter longint unsigned MAX_COLUMN      = stt_pkg::MaxColumnDefault,
   parameter longint unsigned MAX_WORD_LENGTH = stt_pkg::MaxWordLengthDefault
) (
   input logic       clock,
   input logic       reset,
   stt_req_if.sink   req_ch,
   stt_rsp_if.source rsp_ch
);

   logic                push;
   stt_pkg::bundle_type push_bundle;
   logic                full;
   logic                pop;
   logic                empty;
   stt_pkg::bundle_type head;

   // Scanner.
   stt_front #(
      .MAX_LINE        (MAX_LINE),
      .MAX_COLUMN      (MAX_COLUMN),
      .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .queue_full  (full),
      .push        (push),
      .push_bundle (push_bundle)
   );

   // Bundle queue.
   stt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .full        (full),
      .pop         (pop),
      .empty       (empty),
      .head        (head)
   );

   // Token output.
   stt_back u_back (
      .clock  (clock),
      .reset  (reset),
      .empty  (empty),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- hdl/stt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer front end
// Scans one text byte per cycle while the queue has room, keeps the
// scanner state and gathers the tokens the byte completes into a queue bundle.
// ----------------------------------------------------------------------------
module stt_front #(
   parameter longint unsigned MAX_LINE        = stt_pkg::MaxLineDefault,
   parameter longint unsigned MAX_COLUMN      = stt_pkg::MaxColumnDefault,
   parameter longint unsigned MAX_WORD_LENGTH = stt_pkg::MaxWordLengthDefault
) (
   input  logic                clock,
   input  logic                reset,
   stt_req_if.sink             req_ch,
   input  logic                queue_full,
   output logic                push,
   output stt_pkg::bundle_type push_bundle
);

   localparam int LINE_W = $clog2(MAX_LINE + 64'd1);
   localparam int COL_W  = $clog2(MAX_COLUMN + 64'd1);
   localparam int WLEN_W = $clog2(MAX_WORD_LENGTH + 64'd1);

   localparam logic [1:0] ModeIdle    = 2'd0;
   localparam logic [1:0] ModeWord    = 2'd1;
   localparam logic [1:0] ModeHeld    = 2'd2;
   localparam logic [1:0] ModeComment = 2'd3;

   logic [1:0]                mode_ff,   mode_in;
   logic [stt_pkg::ByteW-1:0] held_ff,   held_in;
   logic [WLEN_W-1:0]         wlen_ff,   wlen_in;
   logic [COL_W-1:0]          wcol_ff,   wcol_in;
   logic                      digits_ff, digits_in;
   logic [3:0]                kw_ff,     kw_in;
   logic [LINE_W-1:0]         line_ff,   line_in;
   logic [COL_W-1:0]          col_ff,    col_in;
   logic                      cr_ff,     cr_in;

   stt_pkg::bundle_type       bundle;
   logic                      accept;
   logic [stt_pkg::ByteW-1:0] c;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign c            = req_ch.text_byte;

   // Scanner step: mirrors the byte-by-byte flow, emitting into bundle slots.
   always_comb begin
      logic done;
      mode_in   = mode_ff;
      held_in   = held_ff;
      wlen_in   = wlen_ff;
      wcol_in   = wcol_ff;
      digits_in = digits_ff;
      kw_in     = kw_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      cr_in     = 1'b0;
      bundle    = '0;
      done      = 1'b0;

      if (cr_ff && c == 8'd10) begin
         // The LF of a CR LF pair has already been counted.
         done = 1'b1;
      end

      // Inside a comment only a line end matters.
      if (!done && mode_in == ModeComment) begin
         if (c == 8'd10 || c == 8'd13) begin
            if (line_in < LINE_W'(MAX_LINE)) line_in = line_in + LINE_W'(1);
            col_in  = '0;
            cr_in   = (c == 8'd13);
            mode_in = ModeIdle;
         end
         done = 1'b1;
      end

      // A held symbol either pairs with this byte, opens a comment or goes out alone.
      if (!done && mode_in == ModeHeld) begin
         if (c == "=" && (held_in == "=" || held_in == "<" || held_in == ">" ||
                          held_in == "!")) begin
            if (col_in < COL_W'(MAX_COLUMN)) col_in = col_in + COL_W'(1);
            if (bundle.cnt != stt_pkg::SlotW'(stt_pkg::BundleSlots)) begin
               bundle.tok[bundle.cnt] = stt_pkg::tok_make(stt_pkg::pair_kind(held_in),
                  64'(line_in), 64'(wcol_in), 64'd2);
               bundle.cnt = bundle.cnt + 2'd1;
            end
            mode_in = ModeIdle;
            done    = 1'b1;
         end else if (held_in == "/" && c == "/") begin
            col_in  = wcol_in;
            mode_in = ModeComment;
            done    = 1'b1;
         end else begin
            if (bundle.cnt != stt_pkg::SlotW'(stt_pkg::BundleSlots)) begin
               bundle.tok[bundle.cnt] = stt_pkg::tok_make(stt_pkg::single_kind(held_in),
                  64'(line_in), 64'(wcol_in), 64'd1);
               bundle.cnt = bundle.cnt + 2'd1;
            end
            mode_in = ModeIdle;
         end
      end

      // A word grows on word bytes and is emitted on anything else.
      if (!done && mode_in == ModeWord) begin
         if (!stt_pkg::is_space(c) && !stt_pkg::is_symbol(c)) begin
            if (wlen_in < WLEN_W'(MAX_WORD_LENGTH)) wlen_in = wlen_in + WLEN_W'(1);
            if (!stt_pkg::is_digit(c)) digits_in = 1'b0;
            kw_in = stt_pkg::kw_next(kw_in, c);
            if (col_in < COL_W'(MAX_COLUMN)) col_in = col_in + COL_W'(1);
            done = 1'b1;
         end else begin
            if (bundle.cnt != stt_pkg::SlotW'(stt_pkg::BundleSlots)) begin
               bundle.tok[bundle.cnt] = stt_pkg::tok_make(
                  stt_pkg::word_kind(digits_in, kw_in),
                  64'(line_in), 64'(wcol_in), 64'(wlen_in));
               bundle.cnt = bundle.cnt + 2'd1;
            end
            mode_in = ModeIdle;
         end
      end

      // Between tokens: whitespace, symbols and the first byte of a word.
      if (!done) begin
         if (stt_pkg::is_space(c)) begin
            if (c == 8'd10 || c == 8'd13) begin
               if (line_in < LINE_W'(MAX_LINE)) line_in = line_in + LINE_W'(1);
               col_in = '0;
               cr_in  = (c == 8'd13);
            end else begin
               if (col_in < COL_W'(MAX_COLUMN)) col_in = col_in + COL_W'(1);
            end
         end else if (stt_pkg::is_symbol(c)) begin
            if (c == "=" || c == "<" || c == ">" || c == "!" || c == "/") begin
               held_in = c;
               wcol_in = col_in;
               mode_in = ModeHeld;
            end else if (bundle.cnt != stt_pkg::SlotW'(stt_pkg::BundleSlots)) begin
               bundle.tok[bundle.cnt] = stt_pkg::tok_make(stt_pkg::single_kind(c),
                  64'(line_in), 64'(col_in), 64'd1);
               bundle.cnt = bundle.cnt + 2'd1;
            end
            if (col_in < COL_W'(MAX_COLUMN)) col_in = col_in + COL_W'(1);
         end else begin
            wcol_in   = col_in;
            wlen_in   = WLEN_W'(1);
            digits_in = stt_pkg::is_digit(c);
            kw_in     = stt_pkg::kw_next(stt_pkg::KwStart, c);
            mode_in   = ModeWord;
            if (col_in < COL_W'(MAX_COLUMN)) col_in = col_in + COL_W'(1);
         end
      end

      // End of text: flush the pending token, add the end token, start afresh.
      if (req_ch.end_of_text) begin
         if (mode_in == ModeWord) begin
            if (bundle.cnt != stt_pkg::SlotW'(stt_pkg::BundleSlots)) begin
               bundle.tok[bundle.cnt] = stt_pkg::tok_make(
                  stt_pkg::word_kind(digits_in, kw_in),
                  64'(line_in), 64'(wcol_in), 64'(wlen_in));
               bundle.cnt = bundle.cnt + 2'd1;
            end
         end else if (mode_in == ModeHeld) begin
            if (bundle.cnt != stt_pkg::SlotW'(stt_pkg::BundleSlots)) begin
               bundle.tok[bundle.cnt] = stt_pkg::tok_make(stt_pkg::single_kind(held_in),
                  64'(line_in), 64'(wcol_in), 64'd1);
               bundle.cnt = bundle.cnt + 2'd1;
            end
         end
         if (bundle.cnt != stt_pkg::SlotW'(stt_pkg::BundleSlots)) begin
            bundle.tok[bundle.cnt] = stt_pkg::tok_make(stt_pkg::KindEnd,
               64'(line_in), 64'(col_in), 64'd0);
            bundle.cnt = bundle.cnt + 2'd1;
         end
         mode_in   = ModeIdle;
         held_in   = '0;
         wlen_in   = '0;
         wcol_in   = '0;
         digits_in = 1'b1;
         kw_in     = stt_pkg::KwStart;
         line_in   = LINE_W'(1);
         col_in    = '0;
         cr_in     = 1'b0;
      end
   end

   // Only bundles that hold a token go into the queue.
   assign push        = accept && (bundle.cnt != '0);
   assign push_bundle = bundle;

   // Scanner state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ModeIdle;
         held_ff   <= '0;
         wlen_ff   <= '0;
         wcol_ff   <= '0;
         digits_ff <= 1'b1;
         kw_ff     <= stt_pkg::KwStart;
         line_ff   <= LINE_W'(1);
         col_ff    <= '0;
         cr_ff     <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         wlen_ff   <= wlen_in;
         wcol_ff   <= wcol_in;
         digits_ff <= digits_in;
         kw_ff     <= kw_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         cr_ff     <= cr_in;
      end
   end

endmodule

// ----- hdl/stt_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer bundle queue
// Short first-in first-out queue of token bundles between the front end and
// the back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module stt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stt_pkg::bundle_type push_bundle,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output stt_pkg::bundle_type head
);

   stt_pkg::bundle_type                 entry_ff [stt_pkg::QueueDepth];
   logic [stt_pkg::QueuePtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [stt_pkg::QueuePtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [stt_pkg::QueueCntW-1:0]       count_ff,  count_in;

   assign full  = (count_ff == stt_pkg::QueueCntW'(stt_pkg::QueueDepth));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + stt_pkg::QueuePtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + stt_pkg::QueuePtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + stt_pkg::QueueCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - stt_pkg::QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

// ----- hdl/stt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer back end
// Holds one bundle in the output register and hands its tokens out one per
// response, marking the last token of each bundle.
// ----------------------------------------------------------------------------
module stt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  stt_pkg::bundle_type head,
   output logic                pop,
   stt_rsp_if.source           rsp_ch
);

   stt_pkg::bundle_type          bun_ff;
   logic [stt_pkg::SlotW-1:0]    idx_ff;
   logic                         valid_ff;
   logic                         last;
   stt_pkg::tok_type             tok;

   assign last = (idx_ff == (bun_ff.cnt - stt_pkg::SlotW'(1)));
   assign pop  = !empty && (!valid_ff || (rsp_ch.ready && last));
   assign tok  = bun_ff.tok[idx_ff];

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.token_kind   = tok.kind;
   assign rsp_ch.start_line   = tok.line;
   assign rsp_ch.start_column = tok.column;
   assign rsp_ch.token_length = tok.length;
   assign rsp_ch.run_last     = last;

   // Slot index and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (pop) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (valid_ff && rsp_ch.ready) begin
         if (last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + stt_pkg::SlotW'(1);
         end
      end
   end

   // Bundle being handed out.
   always_ff @(posedge clock) begin
      if (pop) begin
         bun_ff <= head;
      end
   end

endmodule

// ----- hdl/stt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Concurrent assertions on the response port of the tokenizer, bound to the
// top level.
// ----------------------------------------------------------------------------
module stt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [stt_pkg::KindW-1:0]   rsp_kind,
   input logic [stt_pkg::LineW-1:0]   rsp_line,
   input logic [stt_pkg::LengthW-1:0] rsp_length,
   input logic                        rsp_last
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // Reset empties the output.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

   // Only the end token has zero length.
   a_zero_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == stt_pkg::KindEnd) == (rsp_length == '0)))
      else $error("token length does not match its kind");

   // The end token closes the run of its request and lies on a real line.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == stt_pkg::KindEnd |-> rsp_last && rsp_line != '0)
      else $error("end token not last or on line zero");

endmodule

bind source_text_tokenizer stt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_kind   (rsp_ch.token_kind),
   .rsp_line   (rsp_ch.start_line),
   .rsp_length (rsp_ch.token_length),
   .rsp_last   (rsp_ch.run_last)
);

// ----- dv/tb_source_text_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Streams source text into the tokenizer one byte per request and checks
// every token against a cycle-free scanner model kept in the bench. A short
// hand-written text comes first, then random texts of keywords, names,
// numbers, operators, comments and newlines with some noise. Both channels
// idle at random, apart from one long stretch.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;

   // Saturation limits of the default build.
   localparam int unsigned LineLimit   = 32'(stt_pkg::MaxLineDefault);
   localparam int unsigned ColumnLimit = 32'(stt_pkg::MaxColumnDefault);
   localparam int unsigned WordLimit   = 32'(stt_pkg::MaxWordLengthDefault);

   localparam int RandomRequests = 330;
   localparam int IdlePercent    = 17;
   localparam int SteadyFrom     = 150;
   localparam int SteadyTo       = 260;
   localparam int DrainCycles    = 50;
   localparam int CycleLimit     = 1000000;

   // Character codes used by the scanner model.
   localparam logic [stt_pkg::ByteW-1:0] ChTab   = 8'd9;
   localparam logic [stt_pkg::ByteW-1:0] ChLf    = 8'd10;
   localparam logic [stt_pkg::ByteW-1:0] ChVt    = 8'd11;
   localparam logic [stt_pkg::ByteW-1:0] ChFf    = 8'd12;
   localparam logic [stt_pkg::ByteW-1:0] ChCr    = 8'd13;
   localparam logic [stt_pkg::ByteW-1:0] ChSpace = 8'd32;

   typedef enum logic [1:0] {
      ModeIdle,
      ModeWord,
      ModeHeld,
      ModeComment
   } scan_mode_type;

   typedef struct packed {
      logic [stt_pkg::ByteW-1:0] text_byte;
      logic                      end_of_text;
   } text_req_type;

   typedef struct packed {
      logic [stt_pkg::KindW-1:0]   kind;
      logic [stt_pkg::LineW-1:0]   line;
      logic [stt_pkg::ColumnW-1:0] column;
      logic [stt_pkg::LengthW-1:0] length;
      logic                        last;
   } token_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stt_req_if req_ch ();
   stt_rsp_if rsp_ch ();

   source_text_tokenizer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Stimulus and expectation stores.
   text_req_type              text_queue[$];
   logic [stt_pkg::ByteW-1:0] text_build[$];
   token_rec_type             step_tokens[$];
   token_rec_type             expected_tokens[$];
   token_rec_type             oldest_token;

   int accepted_count = 0;
   int received_count = 0;
   int cycle_count    = 0;
   int error_count    = 0;
   int text_count     = 0;

   string punct_set = "()+-*/=;<>!{},.";
   string lead_set  = "abcdefghijklmnopqrstuvwxyz_";
   string word_set  = "abcdefghijklmnopqrstuvwxyzXYZ_0123456789";

   logic steady_stretch;
   assign steady_stretch = (accepted_count >= SteadyFrom) && (accepted_count < SteadyTo);

   // Scanner model state.
   scan_mode_type             scan_mode;
   logic [stt_pkg::ByteW-1:0] held_byte;
   int unsigned               word_len;
   int unsigned               word_col;
   logic                      word_digits;
   logic [3:0]                kw_state;
   int unsigned               line_no;
   int unsigned               col_no;
   logic                      after_cr;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Scanner model
   // ---------------------------------------------------------------------

   function automatic logic is_blank(input logic [stt_pkg::ByteW-1:0] c);
      return (c == ChSpace) || (c >= ChTab && c <= ChCr);
   endfunction

   function automatic logic is_punct(input logic [stt_pkg::ByteW-1:0] c);
      return c inside {"(", ")", "{", "}", "+", "-", "*", "/", "=", ";", "<", ">", "!",
                       ",", "."};
   endfunction

   function automatic logic is_numeral(input logic [stt_pkg::ByteW-1:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   // Bang, comma and dot on their own are reported as identifiers.
   function automatic logic [stt_pkg::KindW-1:0] single_token_kind(
      input logic [stt_pkg::ByteW-1:0] c);
      case (c)
         "+":     return stt_pkg::KindPlus;
         "-":     return stt_pkg::KindMinus;
         "*":     return stt_pkg::KindMultiply;
         "/":     return stt_pkg::KindDivide;
         "=":     return stt_pkg::KindAssign;
         "(":     return stt_pkg::KindLParen;
         ")":     return stt_pkg::KindRParen;
         "{":     return stt_pkg::KindLBrace;
         "}":     return stt_pkg::KindRBrace;
         ";":     return stt_pkg::KindSemicolon;
         ">":     return stt_pkg::KindGt;
         "<":     return stt_pkg::KindLt;
         default: return stt_pkg::KindIdent;
      endcase
   endfunction

   function automatic logic [stt_pkg::KindW-1:0] pair_token_kind(
      input logic [stt_pkg::ByteW-1:0] first);
      case (first)
         "=":     return stt_pkg::KindEq;
         "<":     return stt_pkg::KindLe;
         ">":     return stt_pkg::KindGe;
         default: return stt_pkg::KindNe;
      endcase
   endfunction

   function automatic logic [3:0] keyword_advance(input logic [3:0] s,
                                                  input logic [stt_pkg::ByteW-1:0] c);
      logic [3:0] step;
      step = stt_pkg::KwNone;
      case (s)
         stt_pkg::KwStart:
            if (c == "i") step = stt_pkg::KwI;
            else if (c == "e") step = stt_pkg::KwE;
            else if (c == "p") step = stt_pkg::KwP;
         stt_pkg::KwI:    if (c == "f") step = stt_pkg::KwIf;
         stt_pkg::KwE:    if (c == "l") step = stt_pkg::KwEl;
         stt_pkg::KwEl:   if (c == "s") step = stt_pkg::KwEls;
         stt_pkg::KwEls:  if (c == "e") step = stt_pkg::KwElse;
         stt_pkg::KwP:    if (c == "r") step = stt_pkg::KwPr;
         stt_pkg::KwPr:   if (c == "i") step = stt_pkg::KwPri;
         stt_pkg::KwPri:  if (c == "n") step = stt_pkg::KwPrin;
         stt_pkg::KwPrin: if (c == "t") step = stt_pkg::KwPrint;
         default: step = stt_pkg::KwNone;
      endcase
      return step;
   endfunction

   function automatic logic [stt_pkg::KindW-1:0] word_token_kind();
      if (word_digits) return stt_pkg::KindNumber;
      if (kw_state == stt_pkg::KwIf) return stt_pkg::KindIf;
      if (kw_state == stt_pkg::KwElse) return stt_pkg::KindElse;
      if (kw_state == stt_pkg::KwPrint) return stt_pkg::KindPrint;
      return stt_pkg::KindIdent;
   endfunction

   task automatic reset_scanner();
      scan_mode   = ModeIdle;
      held_byte   = '0;
      word_len    = 0;
      word_col    = 0;
      word_digits = 1'b1;
      kw_state    = stt_pkg::KwStart;
      line_no     = 1;
      col_no      = 0;
      after_cr    = 1'b0;
   endtask

   task automatic note_token(input logic [stt_pkg::KindW-1:0] kind,
                             input int unsigned column, input int unsigned length);
      token_rec_type t;
      t.kind   = kind;
      t.line   = (line_no > 32'hFFFF) ? '1 : line_no[stt_pkg::LineW-1:0];
      t.column = (column > 32'hFFFF) ? '1 : column[stt_pkg::ColumnW-1:0];
      t.length = (length > 32'hFF) ? '1 : length[stt_pkg::LengthW-1:0];
      t.last   = 1'b0;
      step_tokens.push_back(t);
   endtask

   task automatic advance_column();
      if (col_no < ColumnLimit) col_no++;
   endtask

   task automatic start_new_line(input logic [stt_pkg::ByteW-1:0] c);
      if (line_no < LineLimit) line_no++;
      col_no   = 0;
      after_cr = (c == ChCr);
   endtask

   task automatic consume_byte(input logic [stt_pkg::ByteW-1:0] c);
      // Inside a comment only a newline matters; it also resets the column.
      if (scan_mode == ModeComment) begin
         if (c == ChLf || c == ChCr) begin
            start_new_line(c);
            scan_mode = ModeIdle;
         end
         return;
      end
      // A held symbol either pairs with this byte, opens a comment or is
      // emitted on its own before the byte is scanned afresh.
      if (scan_mode == ModeHeld) begin
         if (c == "=" && (held_byte inside {"=", "<", ">", "!"})) begin
            advance_column();
            note_token(pair_token_kind(held_byte), word_col, 2);
            scan_mode = ModeIdle;
            return;
         end
         if (held_byte == "/" && c == "/") begin
            col_no    = word_col;
            scan_mode = ModeComment;
            return;
         end
         note_token(single_token_kind(held_byte), word_col, 1);
         scan_mode = ModeIdle;
      end
      // A word grows until whitespace or a symbol ends it.
      if (scan_mode == ModeWord) begin
         if (!is_blank(c) && !is_punct(c)) begin
            if (word_len < WordLimit) word_len++;
            if (!is_numeral(c)) word_digits = 1'b0;
            kw_state = keyword_advance(kw_state, c);
            advance_column();
            return;
         end
         note_token(word_token_kind(), word_col, word_len);
         scan_mode = ModeIdle;
      end
      if (is_blank(c)) begin
         if (c == ChLf || c == ChCr) start_new_line(c);
         else advance_column();
         return;
      end
      // Symbols that may start a pair or a comment are held for one byte.
      if (is_punct(c)) begin
         if (c inside {"=", "<", ">", "!", "/"}) begin
            held_byte = c;
            word_col  = col_no;
            scan_mode = ModeHeld;
         end else begin
            note_token(single_token_kind(c), col_no, 1);
         end
         advance_column();
         return;
      end
      word_col    = col_no;
      word_len    = 1;
      word_digits = is_numeral(c);
      kw_state    = keyword_advance(stt_pkg::KwStart, c);
      scan_mode   = ModeWord;
      advance_column();
   endtask

   // Works out the tokens that one accepted request causes.
   task automatic predict_tokens(input logic [stt_pkg::ByteW-1:0] c, input logic eot);
      token_rec_type t;
      step_tokens.delete();
      // The LF of a CR LF pair is swallowed.
      if (after_cr && c == ChLf) begin
         after_cr = 1'b0;
      end else begin
         after_cr = 1'b0;
         consume_byte(c);
      end
      // End of text flushes the pending token, adds the end token and
      // returns the scanner to its reset state.
      if (eot) begin
         if (scan_mode == ModeWord) note_token(word_token_kind(), word_col, word_len);
         else if (scan_mode == ModeHeld) note_token(single_token_kind(held_byte), word_col, 1);
         note_token(stt_pkg::KindEnd, col_no, 0);
         reset_scanner();
      end
      for (int i = 0; i < step_tokens.size(); i++) begin
         t      = step_tokens[i];
         t.last = (i == step_tokens.size() - 1);
         expected_tokens.push_back(t);
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) text_build.push_back(s[i]);
   endtask

   task automatic append_byte(input logic [stt_pkg::ByteW-1:0] c);
      text_build.push_back(c);
   endtask

   // Moves the text under construction to the request queue.
   task automatic flush_text(input logic eot);
      text_req_type r;
      for (int i = 0; i < text_build.size(); i++) begin
         r.text_byte   = text_build[i];
         r.end_of_text = eot && (i == text_build.size() - 1);
         text_queue.push_back(r);
      end
      text_build.delete();
      if (eot) text_count++;
   endtask

   task automatic append_newline();
      case ($urandom_range(0, 2))
         0: append_byte(ChLf);
         1: append_byte(ChCr);
         default: begin
            append_byte(ChCr);
            append_byte(ChLf);
         end
      endcase
   endtask

   task automatic append_separator();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: append_byte(ChSpace);
         4: ;
         5: append_byte(8'(9 + 2 * $urandom_range(0, 1) + $urandom_range(0, 1)));
         6, 7, 8: append_newline();
         default: repeat ($urandom_range(2, 4)) append_byte(ChSpace);
      endcase
   endtask

   // One random text: mostly well-formed tokens with random content, some
   // noise bytes and symbol runs that break pairs apart.
   task automatic gen_random_text();
      int   count;
      logic [stt_pkg::ByteW-1:0] c;
      count = $urandom_range(0, 10);
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 11))
            0: case ($urandom_range(0, 2))
                  0: append_text("if");
                  1: append_text("else");
                  default: append_text("print");
               endcase
            1: case ($urandom_range(0, 7))
                  0: append_text("i");
                  1: append_text("el");
                  2: append_text("els");
                  3: append_text("pri");
                  4: append_text("ifx");
                  5: append_text("elsee");
                  6: append_text("printf");
                  default: append_text("p");
               endcase
            2: begin
               append_byte(lead_set[$urandom_range(0, lead_set.len() - 1)]);
               repeat ($urandom_range(0, 5))
                  append_byte(word_set[$urandom_range(0, word_set.len() - 1)]);
            end
            3: repeat ($urandom_range(1, 5)) append_byte(8'("0" + $urandom_range(0, 9)));
            4, 5: append_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
            6: case ($urandom_range(0, 3))
                  0: append_text("==");
                  1: append_text("<=");
                  2: append_text(">=");
                  default: append_text("!=");
               endcase
            7: begin
               append_text("//");
               repeat ($urandom_range(0, 5)) begin
                  c = 8'($urandom_range(0, 255));
                  if (c == ChLf || c == ChCr) c = "#";
                  append_byte(c);
               end
               // Now and then the text ends inside the comment.
               if ($urandom_range(0, 7) != 0) append_newline();
            end
            8: append_text("3.5");
            9: append_byte(8'($urandom_range(0, 255)));
            default: repeat ($urandom_range(2, 4))
               append_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
         endcase
         append_separator();
      end
      if (text_build.size() == 0) append_byte(8'($urandom_range(0, 255)));
      flush_text(1'b1);
   endtask

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.text_byte   <= '0;
         req_ch.end_of_text <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_tokens(req_ch.text_byte, req_ch.end_of_text);
            accepted_count <= accepted_count + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (text_queue.size() != 0 &&
                !(($urandom_range(0, 99) < IdlePercent) && !steady_stretch)) begin
               req_ch.valid       <= 1'b1;
               req_ch.text_byte   <= text_queue[0].text_byte;
               req_ch.end_of_text <= text_queue[0].end_of_text;
               void'(text_queue.pop_front());
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Token monitor
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_tokens.size() == 0) begin
               $error("token_kind: expected none, actual %0d", rsp_ch.token_kind);
               error_count++;
            end else begin
               oldest_token = expected_tokens.pop_front();
               if (rsp_ch.token_kind !== oldest_token.kind) begin
                  $error("token_kind: expected %0d, actual %0d", oldest_token.kind,
                         rsp_ch.token_kind);
                  error_count++;
               end
               if (rsp_ch.start_line !== oldest_token.line) begin
                  $error("start_line: expected %0d, actual %0d", oldest_token.line,
                         rsp_ch.start_line);
                  error_count++;
               end
               if (rsp_ch.start_column !== oldest_token.column) begin
                  $error("start_column: expected %0d, actual %0d", oldest_token.column,
                         rsp_ch.start_column);
                  error_count++;
               end
               if (rsp_ch.token_length !== oldest_token.length) begin
                  $error("token_length: expected %0d, actual %0d", oldest_token.length,
                         rsp_ch.token_length);
                  error_count++;
               end
               if (rsp_ch.run_last !== oldest_token.last) begin
                  $error("run_last: expected %0d, actual %0d", oldest_token.last,
                         rsp_ch.run_last);
                  error_count++;
               end
            end
            received_count <= received_count + 1;
         end
         rsp_ch.ready <= !(($urandom_range(0, 99) < IdlePercent) && !steady_stretch);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL source_text_tokenizer");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: build all texts, release reset, wait for the last token.
   // ---------------------------------------------------------------------
   initial begin
      reset_scanner();

      // Hand-written text: keyword, name, pair, number split by a dot, a
      // comment closed by CR LF, a bang pair, byte zero and 255 inside a
      // word, the other blanks, and a held symbol flushed by end of text.
      append_text("if a<=3.5//z");
      append_byte(ChCr);
      append_byte(ChLf);
      append_text("b!=c");
      append_byte(8'h00);
      append_byte(8'hFF);
      append_byte(ChTab);
      append_byte(ChVt);
      append_byte(ChFf);
      append_text(">");
      flush_text(1'b1);

      while (text_queue.size() < RandomRequests) gen_random_text();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (text_queue.size() != 0 || req_ch.valid || expected_tokens.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Tokenised %0d texts from %0d request bytes and checked %0d tokens,",
               text_count, accepted_count, received_count);
      $display("including keywords, operators, comments, newlines and noise bytes.");
      if (error_count == 0) begin
         $display("PASS source_text_tokenizer");
      end else begin
         $display("FAIL source_text_tokenizer");
      end
      $finish;
   end

endmodule
